// ===== rtl/core/krs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// krs_pkg: shared types and constants of the keepout range segmenter
// Holds the field widths, the beat structs of both channels and the
// structs that travel along the cell chain.
// ----------------------------------------------------------------------------
package krs_pkg;

    localparam int KEEPOUT_MAX = 16;
    localparam int ADDR_BITS   = 16;

    localparam int A_W      = ADDR_BITS;
    localparam int E_W      = ADDR_BITS + 1;
    localparam int FILL_W   = 8;
    localparam int IDX_W    = 4;
    localparam int CFG_W    = 5;
    localparam int CNT_W    = $clog2(KEEPOUT_MAX + 1);

    localparam logic REQ_LOAD   = 1'b0;
    localparam logic REQ_ACCESS = 1'b1;

    typedef struct packed {
        logic              req_type;
        logic [IDX_W-1:0]  entry_index;
        logic [A_W-1:0]    entry_start;
        logic [E_W-1:0]    entry_end;
        logic [FILL_W-1:0] entry_fill;
        logic [A_W-1:0]    access_offset;
        logic [A_W-1:0]    access_bytes;
        logic              access_write;
    } t_in;

    typedef struct packed {
        logic [A_W-1:0]    segment_offset;
        logic [A_W-1:0]    segment_bytes;
        logic              segment_is_keepout;
        logic [FILL_W-1:0] fill_byte;
        logic              segment_write;
        logic              last;
    } t_out;

    typedef struct packed {
        logic [A_W-1:0]    start;
        logic [E_W-1:0]    stop;
        logic [FILL_W-1:0] fill;
    } t_entry;

    typedef struct packed {
        logic           vld;
        logic           skip;
        logic [E_W-1:0] off;
        logic [E_W-1:0] lim;
        logic           wr;
    } t_tok;

    typedef struct packed {
        logic              vld;
        logic [A_W-1:0]    off;
        logic [A_W-1:0]    len;
        logic              keep;
        logic [FILL_W-1:0] fill;
    } t_seg;

    typedef struct packed {
        logic           vld;
        logic [A_W-1:0] off;
        logic           wr;
    } t_fin;

endpackage

// ===== rtl/core/krs_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// krs_cell: one keepout table entry with its step of the table walk
// Stores one entry. When the walk token sits here it offers at most a
// pass-through segment and then a keepout segment, then hands the token on.
// ----------------------------------------------------------------------------
module krs_cell (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_wr,
    input  krs_pkg::t_entry i_entry,
    input  krs_pkg::t_tok   i_tok,
    input  logic            i_take,
    output krs_pkg::t_tok   o_tok,
    output krs_pkg::t_seg   o_seg
);

    krs_pkg::t_entry r_ent;
    krs_pkg::t_tok   r_tok;
    logic            r_phase;

    logic [krs_pkg::E_W-1:0] s_start;
    logic [krs_pkg::E_W-1:0] kend_p;
    logic [krs_pkg::E_W-1:0] kend_k;
    logic [krs_pkg::E_W-1:0] seg_end;
    logic                    skip_now;
    logic                    act;
    logic                    pass_need;
    logic                    keep_need;
    logic                    handoff;

    always_comb begin
        s_start   = {1'b0, r_ent.start};
        skip_now  = r_tok.skip && (r_ent.stop <= r_tok.off);
        act       = r_tok.vld && i_en && !skip_now;
        kend_p    = (r_tok.lim < s_start) ? r_tok.lim : s_start;
        kend_k    = (r_tok.lim < r_ent.stop) ? r_tok.lim : r_ent.stop;
        pass_need = act && !r_phase && (kend_p > r_tok.off);
        keep_need = act && !pass_need && (kend_k > r_tok.off);
        seg_end   = pass_need ? kend_p : kend_k;
        handoff   = r_tok.vld && !pass_need && (!keep_need || i_take);

        o_seg = '0;
        if (pass_need || keep_need) begin
            o_seg.vld  = 1'b1;
            o_seg.off  = r_tok.off[krs_pkg::A_W-1:0];
            o_seg.len  = krs_pkg::A_W'(seg_end - r_tok.off);
            o_seg.keep = !pass_need;
            o_seg.fill = (keep_need && !r_tok.wr) ? r_ent.fill : '0;
        end

        o_tok      = r_tok;
        o_tok.vld  = handoff;
        o_tok.skip = i_en ? skip_now : r_tok.skip;
        if (keep_need) begin
            o_tok.off = kend_k;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_ent <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok.vld <= 1'b0;
            r_phase   <= 1'b0;
        end else if (i_tok.vld) begin
            r_tok   <= i_tok;
            r_phase <= 1'b0;
        end else if (handoff) begin
            r_tok.vld <= 1'b0;
            r_phase   <= 1'b0;
        end else if (pass_need && i_take) begin
            r_tok.off  <= kend_p;
            r_tok.skip <= 1'b0;
            r_phase    <= 1'b1;
        end
    end

endmodule

// ===== rtl/core/krs_collect.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// krs_collect: output stage of the keepout range segmenter
// Holds back the newest segment until it is known whether it is the last
// one of the item, and keeps the output beat in a register of its own.
// ----------------------------------------------------------------------------
module krs_collect (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  krs_pkg::t_seg i_seg,
    input  logic          i_seg_wr,
    input  krs_pkg::t_fin i_fin,
    output logic          o_seg_take,
    output logic          o_fin_take,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output krs_pkg::t_out o_out
);

    krs_pkg::t_out r_out;
    logic          r_out_vld;
    krs_pkg::t_out r_pend;
    logic          r_pend_vld;
    logic          out_free;

    always_comb begin
        out_free    = !r_out_vld || i_out_ready;
        o_seg_take  = i_seg.vld && (!r_pend_vld || out_free);
        o_fin_take  = i_fin.vld && !i_seg.vld && out_free;
        o_out_valid = r_out_vld;
        o_out       = r_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_pend_vld <= 1'b0;
        end else begin
            if (o_seg_take) begin
                if (r_pend_vld) begin
                    r_out     <= r_pend;
                    r_out_vld <= 1'b1;
                end else if (r_out_vld && i_out_ready) begin
                    r_out_vld <= 1'b0;
                end
                r_pend.segment_offset     <= i_seg.off;
                r_pend.segment_bytes      <= i_seg.len;
                r_pend.segment_is_keepout <= i_seg.keep;
                r_pend.fill_byte          <= i_seg.fill;
                r_pend.segment_write      <= i_seg_wr;
                r_pend.last               <= 1'b0;
                r_pend_vld                <= 1'b1;
            end else if (o_fin_take) begin
                if (r_pend_vld) begin
                    r_out.segment_offset     <= r_pend.segment_offset;
                    r_out.segment_bytes      <= r_pend.segment_bytes;
                    r_out.segment_is_keepout <= r_pend.segment_is_keepout;
                    r_out.fill_byte          <= r_pend.fill_byte;
                    r_out.segment_write      <= r_pend.segment_write;
                    r_out.last               <= 1'b1;
                end else begin
                    r_out.segment_offset     <= i_fin.off;
                    r_out.segment_bytes      <= '0;
                    r_out.segment_is_keepout <= 1'b0;
                    r_out.fill_byte          <= '0;
                    r_out.segment_write      <= i_fin.wr;
                    r_out.last               <= 1'b1;
                end
                r_out_vld  <= 1'b1;
                r_pend_vld <= 1'b0;
            end else if (r_out_vld && i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

endmodule

// ===== rtl/core/keepout_range_segmenter_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keepout_range_segmenter_top: splits byte accesses around keepout ranges
// Walks a row of table cells with one token and emits the access segments
// in address order, one beat per segment, with last on the final beat.
// ----------------------------------------------------------------------------
// The block takes one input beat at a time. A load beat writes one table
// entry; its acknowledgement is a last beat of zero bytes, and the next
// input beat can be taken once the closing step has passed it to the output
// register. An access beat sends a token along the row of KEEPOUT_MAX cells,
// one cell per cycle while no offered segment waits to be taken, and a cell
// holds it for a second step when it gives a pass-through segment; a final
// tail step and a closing step follow, and an output stall holds the walk.
// The length of the cell row, not the entry count, sets how long it takes.
module keepout_range_segmenter_top (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  krs_pkg::t_in              i_in,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output krs_pkg::t_out             o_out,
    input  logic                      i_cfg_we,
    input  logic [krs_pkg::CFG_W-1:0] i_cfg_wdata
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_TAIL,
        S_FIN
    } t_state;

    t_state                    r_state;
    logic [krs_pkg::CNT_W-1:0] r_cnt;
    krs_pkg::t_tok             r_tail;
    logic [krs_pkg::A_W-1:0]   r_fin_off;
    logic                      r_wr;

    krs_pkg::t_tok             tok [krs_pkg::KEEPOUT_MAX+1];
    krs_pkg::t_seg             cell_seg [krs_pkg::KEEPOUT_MAX];
    krs_pkg::t_seg             tail_seg;
    krs_pkg::t_seg             seg;
    krs_pkg::t_fin             fin;
    krs_pkg::t_entry           entry;
    logic                      accept;
    logic                      is_load;
    logic                      seg_take;
    logic                      fin_take;
    logic [krs_pkg::E_W-1:0]   sum;

    always_comb begin
        o_in_ready = (r_state == S_IDLE);
        accept     = i_in_valid && o_in_ready;
        is_load    = (i_in.req_type == krs_pkg::REQ_LOAD);

        sum = {1'b0, i_in.access_offset} + {1'b0, i_in.access_bytes};
        tok[0].vld  = accept && !is_load;
        tok[0].skip = 1'b1;
        tok[0].off  = {1'b0, i_in.access_offset};
        tok[0].lim  = (sum[krs_pkg::A_W] && (|sum[krs_pkg::A_W-1:0]))
                      ? {1'b1, {krs_pkg::A_W{1'b0}}} : sum;
        tok[0].wr   = i_in.access_write;

        entry.start = i_in.entry_start;
        entry.stop  = i_in.entry_end;
        entry.fill  = i_in.entry_fill;

        tail_seg = '0;
        if ((r_state == S_TAIL) && (r_tail.off < r_tail.lim)) begin
            tail_seg.vld = 1'b1;
            tail_seg.off = r_tail.off[krs_pkg::A_W-1:0];
            tail_seg.len = krs_pkg::A_W'(r_tail.lim - r_tail.off);
        end

        seg = tail_seg;
        for (int i = 0; i < krs_pkg::KEEPOUT_MAX; i++) begin
            seg = seg | cell_seg[i];
        end

        fin.vld = (r_state == S_FIN);
        fin.off = r_fin_off;
        fin.wr  = r_wr;
    end

    for (genvar g = 0; g < krs_pkg::KEEPOUT_MAX; g++) begin : g_cell
        krs_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (32'(r_cnt) > g),
            .i_wr    (accept && is_load && (32'(i_in.entry_index) == g)),
            .i_entry (entry),
            .i_tok   (tok[g]),
            .i_take  (seg_take),
            .o_tok   (tok[g+1]),
            .o_seg   (cell_seg[g])
        );
    end

    krs_collect u_collect (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_seg       (seg),
        .i_seg_wr    (r_wr),
        .i_fin       (fin),
        .o_seg_take  (seg_take),
        .o_fin_take  (fin_take),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            if (i_cfg_we) begin
                if (32'(i_cfg_wdata) > krs_pkg::KEEPOUT_MAX) begin
                    r_cnt <= krs_pkg::CNT_W'(krs_pkg::KEEPOUT_MAX);
                end else begin
                    r_cnt <= krs_pkg::CNT_W'(i_cfg_wdata);
                end
            end
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        if (is_load) begin
                            r_fin_off <= '0;
                            r_wr      <= 1'b0;
                            r_state   <= S_FIN;
                        end else begin
                            r_fin_off <= i_in.access_offset;
                            r_wr      <= i_in.access_write;
                            r_state   <= S_WALK;
                        end
                    end
                end
                S_WALK: begin
                    if (tok[krs_pkg::KEEPOUT_MAX].vld) begin
                        r_tail  <= tok[krs_pkg::KEEPOUT_MAX];
                        r_state <= S_TAIL;
                    end
                end
                S_TAIL: begin
                    if (!tail_seg.vld || seg_take) begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (fin_take) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule
